### rtl/rti_pkg.sv
package rti_pkg;

  localparam int CW          = 16;            // coordinate width, 8 fraction bits
  localparam int EW          = CW + 1;        // edge / offset vectors
  localparam int RW          = 2 * CW + 2;    // R = D x E2
  localparam int QW          = 2 * CW + 3;    // Q = S x E1
  localparam int PW          = 3 * CW + 4;    // one dot-product term
  localparam int DOTW        = 3 * CW + 6;    // det, un, vn, tn
  localparam int DVW         = DOTW - 1;      // positive det, |tn|
  localparam int FRAC        = 16;            // fraction bits of the quotients
  localparam int QBITS       = 31;            // quotient bits below saturation
  localparam int NW          = DVW + QBITS;   // divider remainder width
  localparam int GEOM_STAGES = 5;
  localparam int LATENCY     = GEOM_STAGES + 2 + QBITS + 1;
  localparam int OUTW        = 32;
  localparam int BARYW       = FRAC + 1;
  localparam int EPSW        = 16;
  localparam logic [EPSW-1:0] EPS_RESET = EPSW'(17);

  typedef struct packed {
    logic signed [DOTW-1:0] det;
    logic signed [DOTW-1:0] un;
    logic signed [DOTW-1:0] vn;
    logic signed [DOTW-1:0] tn;
  } dot_t;

endpackage

### rtl/rti_geom.sv
module rti_geom import rti_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic signed [CW-1:0] ray_origin_x,
  input  logic signed [CW-1:0] ray_origin_y,
  input  logic signed [CW-1:0] ray_origin_z,
  input  logic signed [CW-1:0] ray_dir_x,
  input  logic signed [CW-1:0] ray_dir_y,
  input  logic signed [CW-1:0] ray_dir_z,
  input  logic [3*CW-1:0]      vertex_a,
  input  logic [3*CW-1:0]      vertex_b,
  input  logic [3*CW-1:0]      vertex_c,
  output logic                 out_valid,
  output dot_t                 dot
);

  logic signed [CW-1:0] o_in [3];
  logic signed [CW-1:0] d_in [3];
  logic signed [CW-1:0] a_in [3];
  logic signed [CW-1:0] b_in [3];
  logic signed [CW-1:0] c_in [3];

  logic                 v1, v2, v3, v4;
  logic signed [EW-1:0] e1_1 [3], e2_1 [3], s_1 [3];
  logic signed [CW-1:0] d_1  [3];
  logic signed [EW-1:0] e1_2 [3], e2_2 [3], s_2 [3];
  logic signed [CW-1:0] d_2  [3];
  logic signed [2*CW:0]   mr [6];
  logic signed [2*CW+1:0] mq [6];
  logic signed [EW-1:0] e1_3 [3], e2_3 [3], s_3 [3];
  logic signed [CW-1:0] d_3  [3];
  logic signed [RW-1:0] r_3  [3];
  logic signed [QW-1:0] q_3  [3];
  logic signed [PW-1:0] tdet [3], tun [3], tvn [3], ttn [3];

  always_comb begin
    o_in[0] = ray_origin_x;
    o_in[1] = ray_origin_y;
    o_in[2] = ray_origin_z;
    d_in[0] = ray_dir_x;
    d_in[1] = ray_dir_y;
    d_in[2] = ray_dir_z;
    for (int k = 0; k < 3; k++) begin
      a_in[k] = $signed(vertex_a[k*CW +: CW]);
      b_in[k] = $signed(vertex_b[k*CW +: CW]);
      c_in[k] = $signed(vertex_c[k*CW +: CW]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      v4        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v1        <= in_valid;
      v2        <= v1;
      v3        <= v2;
      v4        <= v3;
      out_valid <= v4;
    end
  end

  // edges and origin offset
  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      e1_1[k] <= EW'(b_in[k]) - EW'(a_in[k]);
      e2_1[k] <= EW'(c_in[k]) - EW'(a_in[k]);
      s_1[k]  <= EW'(o_in[k]) - EW'(a_in[k]);
      d_1[k]  <= d_in[k];
    end
  end

  // cross-product partial products
  always_ff @(posedge clk) begin
    mr[0] <= d_1[1] * e2_1[2];
    mr[1] <= d_1[2] * e2_1[1];
    mr[2] <= d_1[2] * e2_1[0];
    mr[3] <= d_1[0] * e2_1[2];
    mr[4] <= d_1[0] * e2_1[1];
    mr[5] <= d_1[1] * e2_1[0];
    mq[0] <= s_1[1] * e1_1[2];
    mq[1] <= s_1[2] * e1_1[1];
    mq[2] <= s_1[2] * e1_1[0];
    mq[3] <= s_1[0] * e1_1[2];
    mq[4] <= s_1[0] * e1_1[1];
    mq[5] <= s_1[1] * e1_1[0];
    for (int k = 0; k < 3; k++) begin
      e1_2[k] <= e1_1[k];
      e2_2[k] <= e2_1[k];
      s_2[k]  <= s_1[k];
      d_2[k]  <= d_1[k];
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      r_3[k]  <= RW'(mr[2*k]) - RW'(mr[2*k+1]);
      q_3[k]  <= QW'(mq[2*k]) - QW'(mq[2*k+1]);
      e1_3[k] <= e1_2[k];
      e2_3[k] <= e2_2[k];
      s_3[k]  <= s_2[k];
      d_3[k]  <= d_2[k];
    end
  end

  // dot-product terms
  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      tdet[k] <= e1_3[k] * r_3[k];
      tun[k]  <= s_3[k] * r_3[k];
      tvn[k]  <= d_3[k] * q_3[k];
      ttn[k]  <= e2_3[k] * q_3[k];
    end
  end

  always_ff @(posedge clk) begin
    dot.det <= DOTW'(tdet[0]) + DOTW'(tdet[1]) + DOTW'(tdet[2]);
    dot.un  <= DOTW'(tun[0]) + DOTW'(tun[1]) + DOTW'(tun[2]);
    dot.vn  <= DOTW'(tvn[0]) + DOTW'(tvn[1]) + DOTW'(tvn[2]);
    dot.tn  <= DOTW'(ttn[0]) + DOTW'(ttn[1]) + DOTW'(ttn[2]);
  end

endmodule

### rtl/rti_divider.sv
module rti_divider import rti_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic [NW-1:0]    num,
  input  logic [DVW-1:0]   den,
  output logic             out_valid,
  output logic [QBITS-1:0] quot
);

  // restoring division, one quotient bit per stage, MSB first;
  // num must be below den * 2^QBITS
  logic             vld [QBITS];
  logic [NW-1:0]    rem [QBITS];
  logic [DVW-1:0]   dv  [QBITS];
  logic [QBITS-1:0] qt  [QBITS];

  for (genvar k = 0; k < QBITS; k++) begin : g_stage
    localparam int B = QBITS - 1 - k;
    logic             vin;
    logic [NW-1:0]    rin;
    logic [DVW-1:0]   din;
    logic [QBITS-1:0] qin;
    logic [NW-1:0]    sub;

    if (k == 0) begin : g_first
      assign vin = in_valid;
      assign rin = num;
      assign din = den;
      assign qin = '0;
    end else begin : g_next
      assign vin = vld[k-1];
      assign rin = rem[k-1];
      assign din = dv[k-1];
      assign qin = qt[k-1];
    end

    assign sub = NW'(din) << B;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else begin
        vld[k] <= vin;
      end
    end

    always_ff @(posedge clk) begin
      dv[k] <= din;
      if (rin >= sub) begin
        rem[k] <= rin - sub;
        qt[k]  <= qin | (QBITS'(1) << B);
      end else begin
        rem[k] <= rin;
        qt[k]  <= qin;
      end
    end
  end

  assign out_valid = vld[QBITS-1];
  assign quot      = qt[QBITS-1];

endmodule

### rtl/ray_triangle_intersect_core.sv
// Front-face ray/triangle intersection (Moller-Trumbore), fully pipelined.
// Input: drive the ray and vertex ports and pulse start; the item is taken
// at every rising edge with start high and busy low. busy stays low, so a
// new test can enter on every cycle: throughput is one test per clock.
// Output: done is high for one cycle with is_hit, distance, bary_u and
// bary_v; the result is registered through five geometry stages, a compare
// stage, a setup stage, 31 divider stages and the output register. The
// 31-stage bit-per-stage dividers set latency.
// The receiver cannot hold results off; results leave in input order.
// On a miss distance, bary_u and bary_v are zero. distance saturates.
// Config: det_epsilon is written over cfg_valid/cfg_ready/cfg_data, one
// transfer per write; cfg_ready is always high. Write it only while no
// test is in flight.
// Reset (rst, synchronous) empties the pipeline and sets det_epsilon to 17.
module ray_triangle_intersect_core import rti_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  output logic                   busy,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [EPSW-1:0]        cfg_data,
  input  logic signed [CW-1:0]   ray_origin_x,
  input  logic signed [CW-1:0]   ray_origin_y,
  input  logic signed [CW-1:0]   ray_origin_z,
  input  logic signed [CW-1:0]   ray_dir_x,
  input  logic signed [CW-1:0]   ray_dir_y,
  input  logic signed [CW-1:0]   ray_dir_z,
  input  logic [3*CW-1:0]        vertex_a,
  input  logic [3*CW-1:0]        vertex_b,
  input  logic [3*CW-1:0]        vertex_c,
  output logic                   done,
  output logic                   is_hit,
  output logic signed [OUTW-1:0] distance,
  output logic [BARYW-1:0]       bary_u,
  output logic [BARYW-1:0]       bary_v
);

  localparam logic signed [OUTW-1:0] DIST_MAX = {1'b0, {(OUTW-1){1'b1}}};
  localparam logic signed [OUTW-1:0] DIST_MIN = {1'b1, {(OUTW-1){1'b0}}};
  localparam logic [BARYW:0]         BARY_ONE = (BARYW+1)'(1) << FRAC;

  logic [EPSW-1:0] eps;
  logic            geom_valid;
  dot_t            dot;

  logic                 hit_c;
  logic signed [DOTW:0] uv_sum;
  logic [DOTW-1:0]      tn_abs;

  logic           v6, hit6, neg6;
  logic [DVW-1:0] det6, mag6, un6, vn6;
  logic           v7, hit7, neg7, sat7;
  logic [NW-1:0]  tnum7, unum7, vnum7;
  logic [DVW-1:0] den7;

  logic             div_valid;
  logic [QBITS-1:0] qt_t, qt_u, qt_v;
  logic             fl_hit [QBITS];
  logic             fl_neg [QBITS];
  logic             fl_sat [QBITS];

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      eps <= EPS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      eps <= cfg_data;
    end
  end

  rti_geom u_geom (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (start && !busy),
    .ray_origin_x (ray_origin_x),
    .ray_origin_y (ray_origin_y),
    .ray_origin_z (ray_origin_z),
    .ray_dir_x    (ray_dir_x),
    .ray_dir_y    (ray_dir_y),
    .ray_dir_z    (ray_dir_z),
    .vertex_a     (vertex_a),
    .vertex_b     (vertex_b),
    .vertex_c     (vertex_c),
    .out_valid    (geom_valid),
    .dot          (dot)
  );

  // hit test against the undivided determinant
  always_comb begin
    uv_sum = (DOTW+1)'(dot.un) + (DOTW+1)'(dot.vn);
    hit_c  = (dot.det > $signed(DOTW'(eps))) && !dot.un[DOTW-1] &&
             (dot.un <= dot.det) && !dot.vn[DOTW-1] &&
             (uv_sum <= (DOTW+1)'(dot.det));
    tn_abs = dot.tn[DOTW-1] ? DOTW'(-dot.tn) : DOTW'(dot.tn);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v6 <= 1'b0;
      v7 <= 1'b0;
    end else begin
      v6 <= geom_valid;
      v7 <= v6;
    end
  end

  always_ff @(posedge clk) begin
    hit6 <= hit_c;
    neg6 <= dot.tn[DOTW-1];
    det6 <= dot.det[DVW-1:0];
    mag6 <= tn_abs[DVW-1:0];
    un6  <= dot.un[DVW-1:0];
    vn6  <= dot.vn[DVW-1:0];
  end

  // |t| >= 2^15 saturates; only in-range numerators reach the divider
  always_ff @(posedge clk) begin
    hit7  <= hit6;
    neg7  <= neg6;
    sat7  <= NW'(mag6) >= (NW'(det6) << (QBITS - FRAC));
    den7  <= det6;
    tnum7 <= (hit6 && (NW'(mag6) < (NW'(det6) << (QBITS - FRAC)))) ?
             (NW'(mag6) << FRAC) : '0;
    unum7 <= hit6 ? (NW'(un6) << FRAC) : '0;
    vnum7 <= hit6 ? (NW'(vn6) << FRAC) : '0;
  end

  rti_divider u_div_t (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v7),
    .num       (tnum7),
    .den       (den7),
    .out_valid (div_valid),
    .quot      (qt_t)
  );

  rti_divider u_div_u (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v7),
    .num       (unum7),
    .den       (den7),
    .out_valid (),
    .quot      (qt_u)
  );

  rti_divider u_div_v (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v7),
    .num       (vnum7),
    .den       (den7),
    .out_valid (),
    .quot      (qt_v)
  );

  // flags ride alongside the dividers
  always_ff @(posedge clk) begin
    fl_hit[0] <= hit7;
    fl_neg[0] <= neg7;
    fl_sat[0] <= sat7;
    for (int k = 1; k < QBITS; k++) begin
      fl_hit[k] <= fl_hit[k-1];
      fl_neg[k] <= fl_neg[k-1];
      fl_sat[k] <= fl_sat[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= div_valid;
    end
  end

  always_ff @(posedge clk) begin
    is_hit <= fl_hit[QBITS-1];
    if (!fl_hit[QBITS-1]) begin
      distance <= '0;
      bary_u   <= '0;
      bary_v   <= '0;
    end else begin
      if (fl_sat[QBITS-1]) begin
        distance <= fl_neg[QBITS-1] ? DIST_MIN : DIST_MAX;
      end else begin
        distance <= fl_neg[QBITS-1] ? -$signed(OUTW'(qt_t)) : $signed(OUTW'(qt_t));
      end
      bary_u <= qt_u[BARYW-1:0];
      bary_v <= qt_v[BARYW-1:0];
    end
  end

  a_miss_zero : assert property (@(posedge clk) disable iff (rst)
    (done && !is_hit) |-> (distance == '0 && bary_u == '0 && bary_v == '0))
    else $error("miss result carries nonzero payload");

  a_bary_sum : assert property (@(posedge clk) disable iff (rst)
    (done && is_hit) |-> ((BARYW+1)'(bary_u) + (BARYW+1)'(bary_v) <= BARY_ONE))
    else $error("barycentric u + v above one");

  a_latency : assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, LATENCY))
    else $error("result without a matching accepted item");

endmodule
